/* rtl/core/dual_next_hop_route_table_macros.svh */
// Assertion macros for the dual next-hop route table
`ifndef DUAL_NEXT_HOP_ROUTE_TABLE_MACROS_SVH
`define DUAL_NEXT_HOP_ROUTE_TABLE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define DNHRT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define DNHRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/dnhrt_pkg.sv */
// Types and constants shared by the route table cells and top level
`default_nettype none

package dnhrt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [15:0] NO_HOP         = 16'hFFFF;
    localparam logic [31:0] MAX_COST       = 32'hFFFF_FFFF;
    localparam logic [19:0] AGE_STEP_RESET = 20'd10000;

    localparam logic [1:0] REG_BASE_ADDR  = 2'd0;
    localparam logic [1:0] REG_ALLOW_BASE = 2'd1;
    localparam logic [1:0] REG_AGE_STEP   = 2'd2;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DROP   = 2'd2,
        OP_AGE    = 2'd3
    } op_t;

    // operation broadcast to every cell for the duration of a scan
    typedef struct packed {
        op_t         op;
        logic [15:0] dst;
        logic [15:0] hop;
        logic [31:0] metric;
        logic [31:0] step;
        logic [31:0] limit;
    } cmd_t;

    // running result handed from cell to cell
    typedef struct packed {
        logic        done;
        logic        acc;
        logic        req;
        logic [15:0] res;
    } carry_t;

endpackage

`default_nettype wire

/* rtl/core/dual_next_hop_route_table.sv */
// Dual next-hop route table: command port, APB registers and chain of entry cells
//
// Usage:
//   Raise start with opcode, dest_id, hop_addr, metric and dest_is_neighbor;
//   the word is taken at a clock edge where start is high and busy is low.
//   The command then walks a chain of TABLE_DEPTH cells, one cell per cycle,
//   each cell holding one destination with its primary and alternate hop.
//   done pulses for one cycle with accepted, chosen_hop and search_request;
//   the result passes the launch register and each cell register in turn.
//   busy drops in the done cycle, so a new start may be taken at its
//   closing edge. No new word is taken while the last one is in the chain,
//   since busy stays high until its done cycle.
//   Results cannot be held off by the receiver; sample them on done.
//   APB registers: 0x0 base station address, 0x4 allow base station hop,
//   0x8 age step. Write them only while busy is low.
//   Reset empties the table (entry count zero), loads the register
//   defaults and aborts any walk in progress. No clearing pass is needed.
`default_nettype none

`include "dual_next_hop_route_table_macros.svh"

module dual_next_hop_route_table
#(
    parameter int TABLE_DEPTH = dnhrt_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] dest_id,
    input  wire logic [15:0] hop_addr,
    input  wire logic [31:0] metric,
    input  wire logic        dest_is_neighbor,
    output logic             done,
    output logic             accepted,
    output logic [15:0]      chosen_hop,
    output logic             search_request
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [15:0]         base_addr_reg;
    logic                allow_base_reg;
    logic [19:0]         age_step_reg;
    logic                busy_reg, busy_next;
    logic                launch_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    dnhrt_pkg::cmd_t     cmd_reg, cmd_next;
    dnhrt_pkg::carry_t   launch_carry_reg, launch_carry_next;
    logic                cfg_wr, take;
    logic [TABLE_DEPTH:0]   tok;
    dnhrt_pkg::carry_t   carry [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] live, app;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign take   = start && !busy_reg;

    always_comb
    begin
        case (paddr[3:2])
            dnhrt_pkg::REG_BASE_ADDR:  prdata = {16'd0, base_addr_reg};
            dnhrt_pkg::REG_ALLOW_BASE: prdata = {31'd0, allow_base_reg};
            dnhrt_pkg::REG_AGE_STEP:   prdata = {12'd0, age_step_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg  <= 16'd0;
            allow_base_reg <= 1'b0;
            age_step_reg   <= dnhrt_pkg::AGE_STEP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                dnhrt_pkg::REG_BASE_ADDR:  base_addr_reg  <= pwdata[15:0];
                dnhrt_pkg::REG_ALLOW_BASE: allow_base_reg <= pwdata[0];
                dnhrt_pkg::REG_AGE_STEP:   age_step_reg   <= pwdata[19:0];
                default:                   base_addr_reg  <= base_addr_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd_next.op     = dnhrt_pkg::op_t'(opcode);
        cmd_next.dst    = dest_id;
        cmd_next.hop    = hop_addr;
        cmd_next.metric = metric;
        cmd_next.step   = {12'd0, age_step_reg};
        cmd_next.limit  = dnhrt_pkg::MAX_COST - {12'd0, age_step_reg};

        launch_carry_next.done = (cmd_next.op == dnhrt_pkg::OP_SET) && !allow_base_reg &&
                                 (hop_addr == base_addr_reg);
        launch_carry_next.acc  = 1'b0;
        launch_carry_next.req  = 1'b0;
        launch_carry_next.res  = (cmd_next.op == dnhrt_pkg::OP_LOOKUP && dest_is_neighbor) ?
                                 dest_id : dnhrt_pkg::NO_HOP;

        busy_next = busy_reg;
        if (take)
            busy_next = 1'b1;
        else if (tok[TABLE_DEPTH-1])
            busy_next = 1'b0;

        count_next = count_reg;
        if (|app)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg          <= cmd_next;
            launch_carry_reg <= launch_carry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= take;
            count_reg  <= count_next;
        end
    end

    assign tok[0]   = launch_reg;
    assign carry[0] = launch_carry_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign live[i] = CNT_W'(i) < count_reg;

        dnhrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .live      (live[i]),
            .token_in  (tok[i]),
            .carry_in  (carry[i]),
            .cmd       (cmd_reg),
            .token_out (tok[i+1]),
            .carry_out (carry[i+1]),
            .append    (app[i])
        );
    end

    assign busy           = busy_reg;
    assign done           = tok[TABLE_DEPTH];
    assign accepted       = carry[TABLE_DEPTH].acc;
    assign chosen_hop     = carry[TABLE_DEPTH].res;
    assign search_request = carry[TABLE_DEPTH].req;

    `DNHRT_ASSERT_ALWAYS(a_done_not_busy, !(done && busy))
    `DNHRT_ASSERT_ALWAYS(a_count_in_range, count_reg <= CNT_W'(TABLE_DEPTH))
    `DNHRT_ASSERT_NEXT(a_start_sets_busy, take, busy && launch_reg)
    `DNHRT_ASSERT_ALWAYS(a_single_append, $onehot0(app))

endmodule

`default_nettype wire

/* rtl/core/dnhrt_cell.sv */
// One route table entry with its slice of the scan logic
`default_nettype none

module dnhrt_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               live,
    input  wire logic               token_in,
    input  wire dnhrt_pkg::carry_t  carry_in,
    input  wire dnhrt_pkg::cmd_t    cmd,
    output logic                    token_out,
    output dnhrt_pkg::carry_t       carry_out,
    output logic                    append
);

    logic [15:0]       dest_reg, ph_reg, ah_reg;
    logic [31:0]       pc_reg, ac_reg;
    logic [15:0]       dest_next, ph_next, ah_next;
    logic [31:0]       pc_next, ac_next;
    logic              wr;
    logic              token_reg;
    dnhrt_pkg::carry_t carry_reg, carry_next;

    always_comb
    begin
        dest_next  = dest_reg;
        ph_next    = ph_reg;
        pc_next    = pc_reg;
        ah_next    = ah_reg;
        ac_next    = ac_reg;
        carry_next = carry_in;
        wr         = 1'b0;
        append     = 1'b0;
        if (token_in)
        begin
            case (cmd.op)
                dnhrt_pkg::OP_SET:
                begin
                    if (!carry_in.done && live && dest_reg == cmd.dst)
                    begin
                        wr              = 1'b1;
                        carry_next.done = 1'b1;
                        carry_next.acc  = 1'b1;
                        if (ph_reg == dnhrt_pkg::NO_HOP || ph_reg == cmd.hop)
                        begin
                            ph_next = cmd.hop;
                            pc_next = cmd.metric;
                        end
                        else if (cmd.metric < pc_reg)
                        begin
                            ah_next = ph_reg;
                            ac_next = pc_reg;
                            ph_next = cmd.hop;
                            pc_next = cmd.metric;
                        end
                        else if (ah_reg == dnhrt_pkg::NO_HOP || ah_reg == cmd.hop ||
                                 cmd.metric < ac_reg)
                        begin
                            ah_next = cmd.hop;
                            ac_next = cmd.metric;
                        end
                        else
                        begin
                            carry_next.acc = 1'b0;
                        end
                    end
                    else if (!carry_in.done && !live)
                    begin
                        // first free slot: append
                        wr              = 1'b1;
                        append          = 1'b1;
                        dest_next       = cmd.dst;
                        ph_next         = cmd.hop;
                        pc_next         = cmd.metric;
                        ah_next         = dnhrt_pkg::NO_HOP;
                        ac_next         = dnhrt_pkg::MAX_COST;
                        carry_next.done = 1'b1;
                        carry_next.acc  = 1'b1;
                    end
                end
                dnhrt_pkg::OP_LOOKUP:
                begin
                    if (live && dest_reg == cmd.dst)
                    begin
                        if (ph_reg == dnhrt_pkg::NO_HOP && ah_reg == dnhrt_pkg::NO_HOP)
                            carry_next.res = dnhrt_pkg::NO_HOP;
                        else if (ph_reg != dnhrt_pkg::NO_HOP && pc_reg <= ac_reg)
                            carry_next.res = ph_reg;
                        else if (ah_reg != dnhrt_pkg::NO_HOP)
                            carry_next.res = ah_reg;
                    end
                end
                dnhrt_pkg::OP_DROP:
                begin
                    if (live && cmd.hop != dnhrt_pkg::NO_HOP)
                    begin
                        wr = 1'b1;
                        if (dest_reg == cmd.hop)
                        begin
                            ph_next = ah_next;
                            pc_next = ac_next;
                            ah_next = dnhrt_pkg::NO_HOP;
                            ac_next = dnhrt_pkg::MAX_COST;
                            if (ph_next == dnhrt_pkg::NO_HOP)
                                carry_next.req = 1'b1;
                        end
                        if (ph_next == cmd.hop)
                        begin
                            ph_next = ah_next;
                            pc_next = ac_next;
                            ah_next = dnhrt_pkg::NO_HOP;
                            ac_next = dnhrt_pkg::MAX_COST;
                        end
                        if (ah_next == cmd.hop)
                        begin
                            ah_next = dnhrt_pkg::NO_HOP;
                            ac_next = dnhrt_pkg::MAX_COST;
                        end
                    end
                end
                dnhrt_pkg::OP_AGE:
                begin
                    if (live)
                    begin
                        wr = 1'b1;
                        if (cmd.limit > pc_reg)
                        begin
                            pc_next = pc_reg + cmd.step;
                        end
                        else
                        begin
                            ph_next = ah_reg;
                            pc_next = ac_reg;
                            ah_next = dnhrt_pkg::NO_HOP;
                            ac_next = dnhrt_pkg::MAX_COST;
                        end
                        if (cmd.limit > ac_next)
                        begin
                            ac_next = ac_next + cmd.step;
                        end
                        else
                        begin
                            ah_next = dnhrt_pkg::NO_HOP;
                            ac_next = dnhrt_pkg::MAX_COST;
                        end
                    end
                end
                default:
                begin
                    carry_next = carry_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            dest_reg <= dest_next;
            ph_reg   <= ph_next;
            pc_reg   <= pc_next;
            ah_reg   <= ah_next;
            ac_reg   <= ac_next;
        end
        if (token_in)
            carry_reg <= carry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_reg <= 1'b0;
        else
            token_reg <= token_in;
    end

    assign token_out = token_reg;
    assign carry_out = carry_reg;

endmodule

`default_nettype wire

/* bench/tb_dual_next_hop_route_table.sv */
// Testbench for the dual next-hop route table: command-port stimulus, APB setup, result check
`default_nettype none

module tb_dual_next_hop_route_table;
    timeunit 1ns;
    timeprecision 1ps;

    import dnhrt_pkg::*;

    localparam int          DEPTH        = TABLE_DEPTH_DEF;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          PHASE_WORDS  = 205;
    localparam logic [1:0]  REG_UNMAPPED = 2'd3;

    typedef struct packed {
        op_t         op;
        logic [15:0] dst;
        logic [15:0] hop;
        logic [31:0] metric;
        logic        nbr;
    } route_cmd_t;

    typedef struct packed {
        logic        acc;
        logic [15:0] hop;
        logic        req;
    } route_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        start = 1'b0;
    wire         busy;
    logic [1:0]  opcode = '0;
    logic [15:0] dest_id = '0;
    logic [15:0] hop_addr = '0;
    logic [31:0] metric = '0;
    logic        dest_is_neighbor = 1'b0;
    wire         done;
    wire         accepted;
    wire  [15:0] chosen_hop;
    wire         search_request;

    dual_next_hop_route_table uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .dest_id          (dest_id),
        .hop_addr         (hop_addr),
        .metric           (metric),
        .dest_is_neighbor (dest_is_neighbor),
        .done             (done),
        .accepted         (accepted),
        .chosen_hop       (chosen_hop),
        .search_request   (search_request)
    );

    // shadow route table and register copy
    bit [15:0]   tbl_dest [DEPTH];
    bit [15:0]   tbl_phop [DEPTH];
    bit [31:0]   tbl_pcost[DEPTH];
    bit [15:0]   tbl_ahop [DEPTH];
    bit [31:0]   tbl_acost[DEPTH];
    int unsigned tbl_count = 0;
    bit [15:0]   cfg_base = 16'd0;
    bit          cfg_allow = 1'b0;
    bit [19:0]   cfg_step = AGE_STEP_RESET;

    route_cmd_t   route_cmds[$];
    route_reply_t route_replies[$];
    route_cmd_t   cur_cmd;
    bit           holding = 1'b0;
    bit           cmd_taken = 1'b0;
    bit           gaps_on = 1'b1;
    int unsigned  cmds_queued = 0;
    int unsigned  replies_checked = 0;
    int unsigned  fail_count = 0;
    int unsigned  idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_alternate(int i);
        tbl_ahop[i]  = NO_HOP;
        tbl_acost[i] = MAX_COST;
    endfunction

    function automatic void promote_alternate(int i);
        tbl_phop[i]  = tbl_ahop[i];
        tbl_pcost[i] = tbl_acost[i];
        clear_alternate(i);
    endfunction

    function automatic route_reply_t predict_route_reply(route_cmd_t c);
        route_reply_t r;
        bit [31:0]    lim;
        bit           hit;
        r.acc = 1'b0;
        r.hop = NO_HOP;
        r.req = 1'b0;
        lim   = MAX_COST - 32'(cfg_step);
        hit   = 1'b0;
        case (c.op)
            OP_SET:
            begin
                if (cfg_allow || c.hop != cfg_base)
                begin
                    for (int i = 0; i < tbl_count && !hit; i++)
                    begin
                        if (tbl_dest[i] == c.dst)
                        begin
                            hit = 1'b1;
                            if (tbl_phop[i] == NO_HOP || tbl_phop[i] == c.hop)
                            begin
                                tbl_phop[i]  = c.hop;
                                tbl_pcost[i] = c.metric;
                                r.acc = 1'b1;
                            end
                            else if (c.metric < tbl_pcost[i])
                            begin
                                tbl_ahop[i]  = tbl_phop[i];
                                tbl_acost[i] = tbl_pcost[i];
                                tbl_phop[i]  = c.hop;
                                tbl_pcost[i] = c.metric;
                                r.acc = 1'b1;
                            end
                            else if (tbl_ahop[i] == NO_HOP || tbl_ahop[i] == c.hop ||
                                     c.metric < tbl_acost[i])
                            begin
                                tbl_ahop[i]  = c.hop;
                                tbl_acost[i] = c.metric;
                                r.acc = 1'b1;
                            end
                        end
                    end
                    if (!hit && tbl_count < DEPTH)
                    begin
                        tbl_dest[tbl_count]  = c.dst;
                        tbl_phop[tbl_count]  = c.hop;
                        tbl_pcost[tbl_count] = c.metric;
                        clear_alternate(tbl_count);
                        tbl_count++;
                        r.acc = 1'b1;
                    end
                end
            end
            OP_LOOKUP:
            begin
                r.hop = c.nbr ? c.dst : NO_HOP;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_dest[i] == c.dst)
                    begin
                        if (tbl_phop[i] == NO_HOP && tbl_ahop[i] == NO_HOP)
                            r.hop = NO_HOP;
                        else if (tbl_phop[i] != NO_HOP && tbl_pcost[i] <= tbl_acost[i])
                            r.hop = tbl_phop[i];
                        else if (tbl_ahop[i] != NO_HOP)
                            r.hop = tbl_ahop[i];
                    end
                end
            end
            OP_DROP:
            begin
                if (c.hop != NO_HOP)
                begin
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        if (tbl_dest[i] == c.hop)
                        begin
                            promote_alternate(i);
                            if (tbl_phop[i] == NO_HOP)
                                r.req = 1'b1;
                        end
                        if (tbl_phop[i] == c.hop)
                            promote_alternate(i);
                        if (tbl_ahop[i] == c.hop)
                            clear_alternate(i);
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (lim > tbl_pcost[i])
                        tbl_pcost[i] += 32'(cfg_step);
                    else
                        promote_alternate(i);
                    if (lim > tbl_acost[i])
                        tbl_acost[i] += 32'(cfg_step);
                    else
                        clear_alternate(i);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic queue_cmd(input op_t op, input logic [15:0] dst, input logic [15:0] hop,
                             input logic [31:0] m, input logic nbr);
        route_cmds.push_back('{op, dst, hop, m, nbr});
        cmds_queued++;
    endtask

    function automatic logic [15:0] pick_dest();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 80)
            return 16'h0100 + 16'($urandom_range(19));
        else if (p < 95)
            return 16'($urandom);
        else if (p < 97)
            return 16'h0000;
        return 16'hFFFF;
    endfunction

    function automatic route_cmd_t random_route_cmd();
        route_cmd_t  c;
        int unsigned p;
        p = $urandom_range(99);
        c.op = p < 40 ? OP_SET : p < 70 ? OP_LOOKUP : p < 85 ? OP_DROP : OP_AGE;
        c.dst = pick_dest();
        p = $urandom_range(99);
        c.hop = p < 55 ? 16'($urandom_range(7)) : p < 75 ? pick_dest() :
                p < 85 ? NO_HOP : 16'($urandom);
        p = $urandom_range(99);
        c.metric = p < 40 ? 32'($urandom_range(1000)) :
                   p < 60 ? MAX_COST - 32'($urandom_range(2000000)) :
                   p < 65 ? 32'd0 : p < 70 ? MAX_COST : 32'($urandom);
        c.nbr = 1'($urandom_range(1));
        return c;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_BASE_ADDR:  cfg_base  = val[15:0];
            REG_ALLOW_BASE: cfg_allow = val[0];
            REG_AGE_STEP:   cfg_step  = val[19:0];
            default:        ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (replies_checked != cmds_queued)
            @(negedge clk);
    endtask

    // driver: one word held until taken; start dropped at random while gaps_on is set
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (cmd_taken)
                holding = 1'b0;
            if (!holding && route_cmds.size() != 0)
            begin
                cur_cmd = route_cmds.pop_front();
                holding = 1'b1;
                opcode           <= cur_cmd.op;
                dest_id          <= cur_cmd.dst;
                hop_addr         <= cur_cmd.hop;
                metric           <= cur_cmd.metric;
                dest_is_neighbor <= cur_cmd.nbr;
            end
            start <= holding && !(gaps_on && $urandom_range(99) < 12);
        end
    end

    // monitor: check results, predict on each taken word
    always @(posedge clk)
    begin
        route_reply_t exp_r;
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            cmd_taken <= start && !busy;
            if (done)
            begin
                if (route_replies.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    exp_r = route_replies.pop_front();
                    replies_checked <= replies_checked + 1;
                    if (accepted !== exp_r.acc)
                        report_mismatch($sformatf("accepted %b, expected %b",
                                                  accepted, exp_r.acc));
                    if (chosen_hop !== exp_r.hop)
                        report_mismatch($sformatf("chosen_hop %h, expected %h",
                                                  chosen_hop, exp_r.hop));
                    if (search_request !== exp_r.req)
                        report_mismatch($sformatf("search_request %b, expected %b",
                                                  search_request, exp_r.req));
                end
            end
            if (start && !busy)
                route_replies.push_back(predict_route_reply('{op_t'(opcode), dest_id,
                                                              hop_addr, metric,
                                                              dest_is_neighbor}));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [15:0] base_v;
        logic        allow_v;
        logic [19:0] step_v;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, register defaults: base station 0, not allowed, step 10000
        queue_cmd(OP_SET,    16'h0001, 16'h0002, 32'd100,        1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0000, 32'd5,          1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0002, 32'd50,         1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0003, 32'd10,         1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0004, 32'd1000,       1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0004, 32'd20,         1'b0);
        queue_cmd(OP_SET,    16'h0001, 16'h0004, 32'd30,         1'b0);
        queue_cmd(OP_LOOKUP, 16'h0001, 16'h0000, 32'd0,          1'b0);
        queue_cmd(OP_LOOKUP, 16'h0009, 16'h0000, 32'd0,          1'b1);
        queue_cmd(OP_LOOKUP, 16'h0009, 16'h0000, 32'd0,          1'b0);
        queue_cmd(OP_SET,    16'hFFFF, NO_HOP,   MAX_COST,       1'b1);
        queue_cmd(OP_LOOKUP, 16'hFFFF, NO_HOP,   MAX_COST,       1'b1);
        queue_cmd(OP_SET,    16'hFFFF, 16'h0007, 32'd0,          1'b0);
        queue_cmd(OP_SET,    16'h0002, 16'h0001, 32'hFFFF_FFF0,  1'b0);
        queue_cmd(OP_SET,    16'h0000, NO_HOP,   32'd3,          1'b0);
        queue_cmd(OP_SET,    16'h0002, 16'h0005, MAX_COST,       1'b0);
        queue_cmd(OP_AGE,    16'h0000, 16'h0000, 32'd0,          1'b0);
        queue_cmd(OP_LOOKUP, 16'h0002, 16'h0000, 32'd0,          1'b0);
        queue_cmd(OP_DROP,   16'h0000, NO_HOP,   32'd0,          1'b0);
        queue_cmd(OP_DROP,   16'h0000, 16'h0003, 32'd0,          1'b0);
        queue_cmd(OP_DROP,   16'h0000, 16'h0001, 32'd0,          1'b0);
        queue_cmd(OP_LOOKUP, 16'h0001, 16'h0000, 32'd0,          1'b1);
        queue_cmd(OP_LOOKUP, 16'h0000, 16'h0000, 32'd0,          1'b1);
        queue_cmd(OP_AGE,    16'hFFFF, 16'hFFFF, MAX_COST,       1'b1);
        queue_cmd(OP_LOOKUP, 16'hFFFF, 16'h0000, 32'd0,          1'b0);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            case (ph)
                0: begin base_v = 16'h0000; allow_v = 1'b0; step_v = AGE_STEP_RESET; end
                1: begin base_v = 16'hFFFF; allow_v = 1'b1; step_v = 20'd1; end
                2: begin base_v = 16'($urandom_range(7)); allow_v = 1'b0; step_v = 20'd1000000; end
                3:
                begin
                    base_v  = 16'($urandom);
                    allow_v = 1'($urandom_range(1));
                    step_v  = 20'($urandom_range(1, 1000000));
                end
                4: begin base_v = 16'($urandom_range(7)); allow_v = 1'b1; step_v = 20'd500000; end
                default:
                begin
                    base_v  = 16'($urandom_range(7));
                    allow_v = 1'b0;
                    step_v  = 20'($urandom_range(1, 1000000));
                end
            endcase
            reg_write(REG_BASE_ADDR,  {16'h0000, base_v});
            reg_write(REG_ALLOW_BASE, {31'd0, allow_v});
            reg_write(REG_AGE_STEP,   {12'd0, step_v});
            if (ph == 2)
                reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
            gaps_on = (ph != 1);
            @(posedge clk);
            repeat (PHASE_WORDS)
            begin
                route_cmds.push_back(random_route_cmd());
                cmds_queued++;
            end
        end

        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        if (route_replies.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", route_replies.size()));
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
